FILE: sv/lnr_pkg.sv
package lnr_pkg;

    // Frame geometry and fixed-point format
    localparam int CHANNELS     = 4;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 8;

    // Configuration register widths and indexes
    localparam int STEP_BITS      = 20;
    localparam int CHAN_CFG_BITS  = 3;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = STEP_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNELS_IN_USE = CFG_INDEX_BITS'(1);
    localparam logic [STEP_BITS-1:0]     PHASE_STEP_RESET    = STEP_BITS'(65536);
    localparam logic [CHAN_CFG_BITS-1:0] CHANNELS_RESET      = CHAN_CFG_BITS'(2);

    // Position arithmetic: one guard bit above both the step and 2.0
    localparam int POS_BITS = ((STEP_BITS > FRAC_BITS + 1) ? STEP_BITS : FRAC_BITS + 1) + 1;
    localparam int CNT_BITS = $clog2(MAX_UPSAMPLE + 1);
    localparam logic [POS_BITS-1:0]  ONE_POS  = POS_BITS'(64'd1 << FRAC_BITS);
    localparam logic [POS_BITS-1:0]  TWO_POS  = POS_BITS'(64'd2 << FRAC_BITS);
    localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'((64'd1 << FRAC_BITS) / MAX_UPSAMPLE);

    // Lane arithmetic
    localparam int PROD_BITS  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int TDATA_BITS = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0]        t_frame;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_TAIL
    } t_state;

    // Control that travels alongside the lane data
    typedef struct packed {
        logic valid;
        logic last_of_run;
        logic end_of_stream;
    } t_ctl;

endpackage

FILE: sv/lnr_seq.sv
module lnr_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  lnr_pkg::t_frame                   i_frame,
    input  logic                              i_last,
    input  logic [lnr_pkg::STEP_BITS-1:0]     i_step,
    input  logic                              i_advance,
    output lnr_pkg::t_ctl                     o_issue,
    output lnr_pkg::t_frame                   o_base,
    output lnr_pkg::t_frame                   o_other,
    output logic [lnr_pkg::FRAC_BITS-1:0]     o_frac
);

    lnr_pkg::t_state                      r_state, n_state;
    logic [lnr_pkg::POS_BITS-1:0]         r_pos, n_pos;
    logic [lnr_pkg::CNT_BITS-1:0]         r_cnt, n_cnt;
    logic [lnr_pkg::STEP_BITS-1:0]        r_next_pos, n_next_pos;
    logic                                 r_have_prev, n_have_prev;
    logic                                 r_last, n_last;
    lnr_pkg::t_frame                      r_cur, n_cur;
    lnr_pkg::t_frame                      r_prev, n_prev;

    logic [lnr_pkg::STEP_BITS-1:0]        w_step;
    logic [lnr_pkg::POS_BITS-1:0]         w_next;
    logic [lnr_pkg::POS_BITS-1:0]         w_pos_after;
    logic                                 w_can;
    logic                                 w_end;

    // Raise a tiny step so one segment yields at most the upsample limit
    assign w_step = (i_step < lnr_pkg::MIN_STEP) ? lnr_pkg::MIN_STEP : i_step;
    assign w_next = r_pos + lnr_pkg::POS_BITS'(w_step);
    assign w_can  = (r_pos < lnr_pkg::ONE_POS) &&
                    (r_cnt < lnr_pkg::CNT_BITS'(lnr_pkg::MAX_UPSAMPLE));
    assign w_end  = (w_next >= lnr_pkg::ONE_POS) ||
                    (r_cnt == lnr_pkg::CNT_BITS'(lnr_pkg::MAX_UPSAMPLE - 1));
    // Position relative to the newer frame once a segment is done
    assign w_pos_after = (r_pos >= lnr_pkg::ONE_POS) ? (r_pos - lnr_pkg::ONE_POS) :
                         '0;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnr_pkg::ST_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_next_pos  <= '0;
            r_have_prev <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_next_pos  <= n_next_pos;
            r_have_prev <= n_have_prev;
            r_last      <= n_last;
        end
    end

    // Frame stores
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_prev <= n_prev;
    end

    // Accept frames and walk the output positions of each segment, one result a cycle while the output advances
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_next_pos  = r_next_pos;
        n_have_prev = r_have_prev;
        n_last      = r_last;
        n_cur       = r_cur;
        n_prev      = r_prev;
        o_ready     = 1'b0;
        o_issue     = '0;
        o_base      = r_prev;
        o_other     = r_cur;
        o_frac      = r_pos[lnr_pkg::FRAC_BITS-1:0];

        unique case (r_state)
            lnr_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cur  = i_frame;
                    n_last = i_last;
                    n_cnt  = '0;
                    if (r_have_prev) begin
                        n_pos   = lnr_pkg::POS_BITS'(r_next_pos);
                        n_state = lnr_pkg::ST_INTERP;
                    end else if (i_last) begin
                        n_pos   = '0;
                        n_state = lnr_pkg::ST_TAIL;
                    end else begin
                        // First frame only primes the block
                        n_prev      = i_frame;
                        n_have_prev = 1'b1;
                        n_next_pos  = '0;
                    end
                end
            end

            lnr_pkg::ST_INTERP: begin
                if (w_can) begin
                    if (i_advance) begin
                        o_issue.valid         = 1'b1;
                        o_issue.last_of_run   = w_end &&
                                                (!r_last || (w_next >= lnr_pkg::TWO_POS));
                        o_issue.end_of_stream = o_issue.last_of_run && r_last;
                        n_pos = w_next;
                        n_cnt = r_cnt + lnr_pkg::CNT_BITS'(1);
                    end
                end else if (r_last) begin
                    n_pos   = w_pos_after;
                    n_cnt   = '0;
                    n_state = lnr_pkg::ST_TAIL;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_next_pos  = w_pos_after[lnr_pkg::STEP_BITS-1:0];
                    n_state     = lnr_pkg::ST_IDLE;
                end
            end

            lnr_pkg::ST_TAIL: begin
                // Right neighbour is missing: repeat the last frame
                o_base  = r_cur;
                o_other = r_cur;
                o_frac  = '0;
                if (w_can) begin
                    if (i_advance) begin
                        o_issue.valid         = 1'b1;
                        o_issue.last_of_run   = w_end;
                        o_issue.end_of_stream = w_end;
                        n_pos = w_next;
                        n_cnt = r_cnt + lnr_pkg::CNT_BITS'(1);
                    end
                end else begin
                    n_have_prev = 1'b0;
                    n_next_pos  = '0;
                    n_state     = lnr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lnr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/lnr_lane.sv
module lnr_lane (
    input  logic                          i_clk,
    input  logic                          i_advance,
    input  logic                          i_active,
    input  lnr_pkg::t_sample              i_base,
    input  lnr_pkg::t_sample              i_other,
    input  logic [lnr_pkg::FRAC_BITS-1:0] i_frac,
    output lnr_pkg::t_sample              o_sample
);

    logic signed [lnr_pkg::SAMPLE_BITS:0]   w_diff;
    logic signed [lnr_pkg::FRAC_BITS:0]     w_frac;
    logic signed [lnr_pkg::PROD_BITS-1:0]   n_prod, r_prod;
    lnr_pkg::t_sample                       n_base, r_base;

    // Difference to the right neighbour, scaled by the fraction
    assign w_diff = {i_other[lnr_pkg::SAMPLE_BITS-1], i_other} -
                    {i_base[lnr_pkg::SAMPLE_BITS-1], i_base};
    assign w_frac = {1'b0, i_frac};

    always_comb begin
        n_prod = '0;
        n_base = '0;
        if (i_active) begin
            n_prod = w_diff * w_frac;
            n_base = i_base;
        end
    end

    // Hold the product while the output side stalls
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod <= n_prod;
            r_base <= n_base;
        end
    end

    // Arithmetic shift floors the product; wrap to the sample width
    assign o_sample = r_base + r_prod[lnr_pkg::FRAC_BITS +: lnr_pkg::SAMPLE_BITS];

endmodule

FILE: sv/lnr_merge.sv
module lnr_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lnr_pkg::t_ctl                       i_issue,
    input  lnr_pkg::t_frame                     i_lanes,
    input  logic                                i_tready,
    output logic                                o_advance,
    output logic                                o_tvalid,
    output logic [lnr_pkg::TDATA_BITS-1:0]      o_tdata,
    output logic                                o_tlast,
    output logic                                o_tuser
);

    lnr_pkg::t_ctl                     r_s1;
    logic                              r_valid;
    logic [lnr_pkg::TDATA_BITS-1:0]    r_data;
    logic                              r_last;
    logic                              r_eos;

    // Move the whole pipe when the output register is free or being taken
    assign o_advance = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_s1    <= i_issue;
            r_valid <= r_s1.valid;
        end
    end

    // Gather the lanes into one result item
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_data <= lnr_pkg::TDATA_BITS'(i_lanes);
            r_last <= r_s1.last_of_run;
            r_eos  <= r_s1.end_of_stream;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;
    assign o_tuser  = r_eos;

endmodule

FILE: sv/linear_interp_resampler.sv
// Pipeline: a result is issued by the sequencer, registered in the lane multiply stage and then in
// the output register (issue, lane multiply, output register); later results follow one a cycle while taken.
// A frame holds the sequencer while it issues its results (n results, 0..16) and ends its segment;
// a last frame after an earlier one also runs the tail, and a priming frame is only stored.
// Reset is synchronous, active low: stream state and valid flags clear, and the
// registers return to phase_step 1.0 and two channels in use.
module linear_interp_resampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lnr_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [lnr_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // Input frames
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [lnr_pkg::TDATA_BITS-1:0]        s_axis_tdata,  // in_0, in_1, in_2, in_3
    input  logic                                  s_axis_tlast,  // last_frame
    // Result frames
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [lnr_pkg::TDATA_BITS-1:0]        m_axis_tdata,  // out_0, out_1, out_2, out_3
    output logic                                  m_axis_tlast,  // last_of_run
    output logic                                  m_axis_tuser   // end_of_stream
);

    logic [lnr_pkg::STEP_BITS-1:0]      r_phase_step;
    logic [lnr_pkg::CHAN_CFG_BITS-1:0]  r_chans;

    lnr_pkg::t_frame                    w_in_frame;
    lnr_pkg::t_frame                    w_base;
    lnr_pkg::t_frame                    w_other;
    lnr_pkg::t_frame                    w_lanes;
    logic [lnr_pkg::FRAC_BITS-1:0]      w_frac;
    lnr_pkg::t_ctl                      w_issue;
    logic                               w_advance;
    logic [lnr_pkg::CHANNELS-1:0]       w_active;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= lnr_pkg::PHASE_STEP_RESET;
            r_chans      <= lnr_pkg::CHANNELS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lnr_pkg::CFG_PHASE_STEP:      r_phase_step <= i_cfg_data;
                lnr_pkg::CFG_CHANNELS_IN_USE: r_chans <= i_cfg_data[lnr_pkg::CHAN_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_frame = s_axis_tdata[lnr_pkg::CHANNELS*lnr_pkg::SAMPLE_BITS-1:0];

    lnr_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_frame   (w_in_frame),
        .i_last    (s_axis_tlast),
        .i_step    (r_phase_step),
        .i_advance (w_advance),
        .o_issue   (w_issue),
        .o_base    (w_base),
        .o_other   (w_other),
        .o_frac    (w_frac)
    );

    // One interpolation lane per channel; lanes at or above the count output zero
    for (genvar c = 0; c < lnr_pkg::CHANNELS; c++) begin : g_lane
        assign w_active[c] = lnr_pkg::CHAN_CFG_BITS'(c) < r_chans;

        lnr_lane u_lane (
            .i_clk     (i_clk),
            .i_advance (w_advance),
            .i_active  (w_active[c]),
            .i_base    (w_base[c]),
            .i_other   (w_other[c]),
            .i_frac    (w_frac),
            .o_sample  (w_lanes[c])
        );
    end

    lnr_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (w_issue),
        .i_lanes   (w_lanes),
        .i_tready  (m_axis_tready),
        .o_advance (w_advance),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule

FILE: sv/lnr_checks.sv
module lnr_checks (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [lnr_pkg::TDATA_BITS-1:0]    m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              m_axis_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item valid after reset");

    // A stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // End of stream is always the last item of its frame
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of stream without last of run");

endmodule

bind linear_interp_resampler lnr_checks u_lnr_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
